@@ hdl/fsmf_pkg.sv @@
// shared types, constants and register codes for the first substring match finder
package fsmf_pkg;

    // default sizing
    localparam int PATTERN_MAX_DEFAULT   = 32;
    localparam int POSITION_BITS_DEFAULT = 32;

    // register space
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_INDEX_BITS = 3;
    localparam int PLEN_BITS      = 6;
    localparam int PAT_WORDS      = 4;
    localparam int PAT_REG_BYTES  = 8 * PAT_WORDS;
    localparam int LEN_CMP_BITS   = 7;
    localparam int START_BITS     = 32;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_PATTERN_WORD0  = 3'd1,
        REG_PATTERN_WORD1  = 3'd2,
        REG_PATTERN_WORD2  = 3'd3,
        REG_PATTERN_WORD3  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } text_item_t;

    typedef struct packed {
        logic                  found;
        logic [START_BITS-1:0] match_start;
    } result_item_t;

    // what one accepted item produces
    typedef struct packed {
        logic                  emit;
        logic                  found;
        logic [START_BITS-1:0] match_start;
    } scan_result_t;

endpackage

@@ hdl/fsmf_pattern.sv @@
// pattern registers and window-aligned pattern bytes
module fsmf_pattern
    import fsmf_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT,
    parameter int LEN_BITS    = $clog2(PATTERN_MAX + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output logic [PATTERN_MAX-1:0][7:0] aligned_pattern,
    output logic [LEN_BITS-1:0]       pattern_len
);

    logic [PLEN_BITS-1:0]                 pattern_length_reg;
    logic [PAT_WORDS-1:0][CFG_DATA_BITS-1:0] pattern_word_reg;
    logic [PAT_REG_BYTES-1:0][7:0]        pattern_bytes;
    logic [LEN_CMP_BITS-1:0]              length_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            pattern_word_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LENGTH: pattern_length_reg  <= cfg_data[PLEN_BITS-1:0];
                REG_PATTERN_WORD0:  pattern_word_reg[0] <= cfg_data;
                REG_PATTERN_WORD1:  pattern_word_reg[1] <= cfg_data;
                REG_PATTERN_WORD2:  pattern_word_reg[2] <= cfg_data;
                REG_PATTERN_WORD3:  pattern_word_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign pattern_bytes = pattern_word_reg;

    // clamp the length to the window depth
    always_comb
    begin
        length_wide = {1'b0, pattern_length_reg};
        if (length_wide > LEN_CMP_BITS'(PATTERN_MAX))
            pattern_len = LEN_BITS'(PATTERN_MAX);
        else
            pattern_len = LEN_BITS'(length_wide);
    end

    // window entry j faces pattern byte len-1-j; bytes past register space read zero
    always_comb
    begin
        aligned_pattern = '0;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            for (int l = j + 1; l <= PATTERN_MAX; l++)
            begin
                if ((l - 1 - j) < PAT_REG_BYTES)
                begin
                    if (pattern_len == LEN_BITS'(l))
                        aligned_pattern[j] = pattern_bytes[l-1-j];
                end
            end
        end
    end

endmodule

@@ hdl/fsmf_scan.sv @@
// byte window, position count and combinational window compare
module fsmf_scan
    import fsmf_pkg::*;
#(
    parameter int PATTERN_MAX   = PATTERN_MAX_DEFAULT,
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
    parameter int LEN_BITS      = $clog2(PATTERN_MAX + 1)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  text_item_t                  item,
    input  logic [PATTERN_MAX-1:0][7:0] aligned_pattern,
    input  logic [LEN_BITS-1:0]         pattern_len,
    output scan_result_t                scan
);

    logic [PATTERN_MAX-1:0][7:0] window_reg;
    logic [PATTERN_MAX-1:0][7:0] window_next;
    logic [POSITION_BITS-1:0]    bytes_seen_reg;
    logic [POSITION_BITS-1:0]    bytes_seen_next;
    logic                        text_done_reg;
    logic                        text_done_next;
    logic [POSITION_BITS-1:0]    count_inc;
    logic [POSITION_BITS-1:0]    len_ext;
    logic [POSITION_BITS-1:0]    start_full;
    logic [START_BITS-1:0]       start_out;
    logic [PATTERN_MAX-1:0]      byte_ok;
    logic                        hit;

    // shifted window: entry 0 is the newest byte
    always_comb
    begin
        window_next[0] = item.text_byte;
        for (int k = 1; k < PATTERN_MAX; k++)
            window_next[k] = window_reg[k-1];
    end

    assign count_inc  = (bytes_seen_reg == '1) ? bytes_seen_reg : bytes_seen_reg + 1'b1;
    assign len_ext    = POSITION_BITS'(pattern_len);
    assign start_full = count_inc - len_ext;

    generate
        if (POSITION_BITS > START_BITS)
        begin : g_start_sat
            assign start_out = (|start_full[POSITION_BITS-1:START_BITS]) ?
                               '1 : start_full[START_BITS-1:0];
        end
        else
        begin : g_start_ext
            assign start_out = START_BITS'(start_full);
        end
    endgenerate

    always_comb
    begin
        for (int j = 0; j < PATTERN_MAX; j++)
            byte_ok[j] = (LEN_BITS'(j) >= pattern_len) || (window_next[j] == aligned_pattern[j]);
    end

    // empty pattern matches at the first byte
    assign hit = (pattern_len == '0) || ((count_inc >= len_ext) && (&byte_ok));

    always_comb
    begin
        bytes_seen_next   = bytes_seen_reg;
        text_done_next    = text_done_reg;
        scan.emit         = 1'b0;
        scan.found        = 1'b0;
        scan.match_start  = '0;
        if (accept)
        begin
            if (text_done_reg)
            begin
                // rest of a matched text: swallow silently
                if (item.last_byte)
                begin
                    bytes_seen_next = '0;
                    text_done_next  = 1'b0;
                end
            end
            else
            begin
                bytes_seen_next = count_inc;
                if (hit)
                begin
                    scan.emit        = 1'b1;
                    scan.found       = 1'b1;
                    scan.match_start = (pattern_len == '0) ? '0 : start_out;
                    text_done_next   = 1'b1;
                end
                else if (item.last_byte)
                begin
                    scan.emit = 1'b1;
                end
                if (item.last_byte)
                begin
                    bytes_seen_next = '0;
                    text_done_next  = 1'b0;
                end
            end
        end
    end

    // window entries are only read once written in the current text
    always_ff @(posedge clk)
    begin
        if (accept && !text_done_reg)
            window_reg <= window_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg <= '0;
            text_done_reg  <= 1'b0;
        end
        else
        begin
            bytes_seen_reg <= bytes_seen_next;
            text_done_reg  <= text_done_next;
        end
    end

endmodule

@@ hdl/first_substring_match_finder.sv @@
// top level of the first substring match finder
// Streams a text one byte per item (last_byte marks the end) and reports the first place where
// the configured pattern of up to PATTERN_MAX bytes occurs. Each text yields exactly one result
// item: found=1 with the start index at the first complete match, or found=0 with index 0 at the
// final byte; bytes after a match are consumed with no result. An empty pattern matches at 0.
// The block takes one text item every cycle unless stalled: the newest byte and the stored
// window are compared against the pattern combinationally and the outcome lands in the result
// register, so a result appears in the cycle after the byte that completes it. The input stalls
// only while a result is held and the output side stalls. The position count saturates at
// POSITION_BITS, match_start at 32 bits; no clearing pass is needed after reset. The user must
// write pattern registers (cfg_write/cfg_index/cfg_data) with no text in progress; unchecked.
module first_substring_match_finder
    import fsmf_pkg::*;
#(
    parameter int PATTERN_MAX   = PATTERN_MAX_DEFAULT,
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration write port
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    // text items in
    input  logic                      text_valid,
    output logic                      text_stall,
    input  text_item_t                text,
    // result items out
    output logic                      result_valid,
    input  logic                      result_stall,
    output result_item_t              result
);

    localparam int LEN_BITS = $clog2(PATTERN_MAX + 1);

    logic [PATTERN_MAX-1:0][7:0] aligned_pattern;
    logic [LEN_BITS-1:0]         pattern_len;
    logic                        text_accept;
    scan_result_t                scan;
    logic                        result_valid_reg;
    logic                        result_valid_next;
    result_item_t                result_reg;

    // hold off new text only while a result is waiting and cannot leave
    assign text_stall  = result_valid_reg && result_stall;
    assign text_accept = text_valid && !text_stall;

    fsmf_pattern #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_BITS    (LEN_BITS)
    ) u_pattern (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .aligned_pattern (aligned_pattern),
        .pattern_len     (pattern_len)
    );

    fsmf_scan #(
        .PATTERN_MAX   (PATTERN_MAX),
        .POSITION_BITS (POSITION_BITS),
        .LEN_BITS      (LEN_BITS)
    ) u_scan (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (text_accept),
        .item            (text),
        .aligned_pattern (aligned_pattern),
        .pattern_len     (pattern_len),
        .scan            (scan)
    );

    // result register: loads a new item, or empties once taken
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (text_accept && scan.emit)
            result_valid_next = 1'b1;
        else if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (text_accept && scan.emit)
        begin
            result_reg.found       <= scan.found;
            result_reg.match_start <= scan.match_start;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
